// File: rtl/core/acm_pkg.sv
// ----------------------------------------------------------------------------
// acm_pkg
// shared command codes and symbol constants for the string matcher
// ----------------------------------------------------------------------------
package acm_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD_PATTERN = 2'd0,
    CMD_LOAD_TEXT    = 2'd1,
    CMD_FIND_NEXT    = 2'd2,
    CMD_UNUSED       = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    REG_PATTERN_LENGTH = 1'b0,
    REG_TEXT_LENGTH    = 1'b1
  } reg_idx_t;

  localparam int SYM_W = 8;
  // pattern symbol past the end, never equal to a byte
  localparam logic [SYM_W:0] NO_SYM = 9'h100;

endpackage

// File: rtl/core/acm_ram.sv
// ----------------------------------------------------------------------------
// acm_ram
// single write port, single read port synchronous memory, registered read
// ----------------------------------------------------------------------------
module acm_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/apostolico_crochemore_matcher.sv
// ----------------------------------------------------------------------------
// apostolico_crochemore_matcher
// exact pattern search over stored text, resumable find-next
// ----------------------------------------------------------------------------
// usage:
//   cfg channel writes pattern_length (index 0) and text_length (index 1)
//   in channel carries commands: load pattern symbol, load text symbol, find
//   loads give no result
//   the first find after a load or register write builds the next table
//   and the leading run length
//   each find then scans the text; a symbol compare is one pattern/text
//   memory read then a compare, and a window shift checks the end of text,
//   reads the next table and moves the window
//   one result item per find: a match position, or finished
//   in_ready is high only while no find is in progress; one find at a time
//   a result waits in the output register while the receiver stalls; loads
//   are still taken, a further find completes its scan then waits
//   reset clears control state and text length, sets pattern length to 1;
//   stores hold unknown data
module apostolico_crochemore_matcher #(
  parameter int PATTERN_MAX = 256,
  parameter int TEXT_MAX    = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  acm_pkg::cmd_t       in_command,
  input  logic [11:0]         in_address,
  input  logic [7:0]          in_symbol,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [11:0]         out_match_position,
  output logic                out_found,
  output logic                out_finished,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  acm_pkg::reg_idx_t   cfg_index,
  input  logic [12:0]         cfg_data
);
  import acm_pkg::*;

  localparam int PW  = $clog2(PATTERN_MAX + 1);
  localparam int SW  = PW + 1;
  localparam int PAW = $clog2(PATTERN_MAX);
  localparam int TW  = $clog2(TEXT_MAX + 1);
  localparam int TAW = $clog2(TEXT_MAX);
  localparam int CW  = ((TW > PW) ? TW : PW) + 2;

  typedef enum logic [15:0] {
    ST_IDLE   = 16'h0001,
    ST_P_LOOP = 16'h0002,
    ST_P_CMP  = 16'h0004,
    ST_P_RD2  = 16'h0008,
    ST_P_CMP2 = 16'h0010,
    ST_R_RD   = 16'h0020,
    ST_R_CMP  = 16'h0040,
    ST_R_FIN  = 16'h0080,
    ST_S_TOP  = 16'h0100,
    ST_S_IRD  = 16'h0200,
    ST_S_ICMP = 16'h0400,
    ST_S_KRD  = 16'h0800,
    ST_S_KCMP = 16'h1000,
    ST_S_NX   = 16'h2000,
    ST_S_UPD  = 16'h4000,
    ST_OUT    = 16'h8000
  } state_t;

  state_t state_r, state_nxt;
  logic [8:0]           pl_r;
  logic [12:0]          tl_r;
  logic                 prepared_r, prepared_nxt;
  logic [PW-1:0]        pi_r, pi_nxt;
  logic signed [SW-1:0] pj_r, pj_nxt;
  logic [PW-1:0]        rl_r, rl_nxt;
  logic [PW-1:0]        ell_r, ell_nxt;
  logic [PW-1:0]        right_r, right_nxt;
  logic [PW-1:0]        left_r, left_nxt;
  logic [TW:0]          ws_r, ws_nxt;
  logic                 hit_r, hit_nxt;
  logic                 oob_r, oob_nxt;
  logic [11:0]          res_pos_r, res_pos_nxt;
  logic                 res_found_r, res_found_nxt;
  logic                 res_fin_r, res_fin_nxt;
  logic                 out_valid_r;
  logic [11:0]          out_pos_r;
  logic                 out_found_r, out_fin_r;

  logic [PW-1:0]        eff_m;
  logic [TW-1:0]        eff_n;
  logic                 in_acc;

  logic [PW-1:0]        pa_idx, pb_idx, nt_ridx, nt_widx;
  logic [TW-1:0]        t_idx;
  logic                 nt_we;
  logic [SW-1:0]        nt_wdata;
  logic [7:0]           pa_rdata, pb_rdata, t_rdata;
  logic [SW-1:0]        nt_rdata;
  logic signed [SW-1:0] nx;
  logic [SYM_W:0]       sym_a, sym_b;
  logic [SW:0]          shift;
  logic                 pat_we, txt_we;

  assign in_acc    = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign pat_we    = in_acc && (in_command == CMD_LOAD_PATTERN) &&
                     (32'(in_address) < PATTERN_MAX);
  assign txt_we    = in_acc && (in_command == CMD_LOAD_TEXT) &&
                     (32'(in_address) < TEXT_MAX);

  always_comb begin
    if (pl_r == 9'd0) begin
      eff_m = PW'(1);
    end else if (32'(pl_r) > PATTERN_MAX) begin
      eff_m = PW'(PATTERN_MAX);
    end else begin
      eff_m = PW'(pl_r);
    end
    if (32'(tl_r) > TEXT_MAX) begin
      eff_n = TW'(TEXT_MAX);
    end else begin
      eff_n = TW'(tl_r);
    end
  end

  // two copies of the pattern give two read ports
  acm_ram #(.DEPTH(PATTERN_MAX), .WIDTH(8)) u_pat_a (
    .clk(clk), .we(pat_we), .waddr(PAW'(in_address)), .wdata(in_symbol),
    .raddr(PAW'(pa_idx)), .rdata(pa_rdata)
  );
  acm_ram #(.DEPTH(PATTERN_MAX), .WIDTH(8)) u_pat_b (
    .clk(clk), .we(pat_we), .waddr(PAW'(in_address)), .wdata(in_symbol),
    .raddr(PAW'(pb_idx)), .rdata(pb_rdata)
  );
  acm_ram #(.DEPTH(TEXT_MAX), .WIDTH(8)) u_txt (
    .clk(clk), .we(txt_we), .waddr(TAW'(in_address)), .wdata(in_symbol),
    .raddr(TAW'(t_idx)), .rdata(t_rdata)
  );
  acm_ram #(.DEPTH(PATTERN_MAX + 1), .WIDTH(SW)) u_next (
    .clk(clk), .we(nt_we), .waddr(nt_widx), .wdata(nt_wdata),
    .raddr(nt_ridx), .rdata(nt_rdata)
  );

  assign nx    = nt_rdata;
  assign sym_a = oob_r ? NO_SYM : {1'b0, pa_rdata};
  assign sym_b = {1'b0, pb_rdata};
  assign shift = (SW+1)'({1'b0, right_r}) - (SW+1)'(nx);

  always_comb begin
    state_nxt     = state_r;
    prepared_nxt  = prepared_r;
    pi_nxt        = pi_r;
    pj_nxt        = pj_r;
    rl_nxt        = rl_r;
    ell_nxt       = ell_r;
    right_nxt     = right_r;
    left_nxt      = left_r;
    ws_nxt        = ws_r;
    hit_nxt       = hit_r;
    oob_nxt       = 1'b0;
    res_pos_nxt   = res_pos_r;
    res_found_nxt = res_found_r;
    res_fin_nxt   = res_fin_r;
    pa_idx        = pi_r;
    pb_idx        = PW'(pj_r);
    nt_ridx       = PW'(pj_r);
    t_idx         = TW'(ws_r);
    nt_we         = 1'b0;
    nt_widx       = pi_r;
    nt_wdata      = SW'(pj_r);
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_command)
            CMD_LOAD_PATTERN, CMD_LOAD_TEXT: prepared_nxt = 1'b0;
            CMD_FIND_NEXT: begin
              if (prepared_r) begin
                state_nxt = ST_S_TOP;
              end else begin
                nt_we     = 1'b1;
                nt_widx   = '0;
                nt_wdata  = '1;
                pi_nxt    = '0;
                pj_nxt    = '1;
                state_nxt = ST_P_LOOP;
              end
            end
            default: ;
          endcase
        end
      end
      ST_P_LOOP: begin
        if (pi_r >= eff_m) begin
          rl_nxt    = PW'(1);
          state_nxt = ST_R_RD;
        end else begin
          state_nxt = ST_P_CMP;
        end
      end
      ST_P_CMP: begin
        if (!pj_r[SW-1] && (sym_a != sym_b)) begin
          pj_nxt    = nx;
          state_nxt = ST_P_LOOP;
        end else begin
          pi_nxt    = pi_r + PW'(1);
          pj_nxt    = pj_r + SW'(1);
          state_nxt = ST_P_RD2;
        end
      end
      ST_P_RD2: begin
        oob_nxt   = (pi_r >= eff_m);
        state_nxt = ST_P_CMP2;
      end
      ST_P_CMP2: begin
        nt_we     = 1'b1;
        nt_wdata  = (sym_a == sym_b) ? nt_rdata : SW'(pj_r);
        state_nxt = ST_P_LOOP;
      end
      ST_R_RD: begin
        pa_idx = rl_r - PW'(1);
        pb_idx = rl_r;
        state_nxt = (rl_r < eff_m) ? ST_R_CMP : ST_R_FIN;
      end
      ST_R_CMP: begin
        if (sym_a == sym_b) begin
          rl_nxt    = rl_r + PW'(1);
          state_nxt = ST_R_RD;
        end else begin
          state_nxt = ST_R_FIN;
        end
      end
      ST_R_FIN: begin
        ell_nxt      = (rl_r == eff_m) ? '0 : rl_r;
        right_nxt    = (rl_r == eff_m) ? '0 : rl_r;
        left_nxt     = '0;
        ws_nxt       = '0;
        prepared_nxt = 1'b1;
        state_nxt    = ST_S_TOP;
      end
      ST_S_TOP: begin
        hit_nxt = 1'b0;
        if (CW'(ws_r) + CW'(eff_m) > CW'(eff_n)) begin
          res_pos_nxt   = '0;
          res_found_nxt = 1'b0;
          res_fin_nxt   = 1'b1;
          state_nxt     = ST_OUT;
        end else begin
          state_nxt = ST_S_IRD;
        end
      end
      ST_S_IRD: begin
        pa_idx = right_r;
        t_idx  = TW'(ws_r) + TW'(right_r);
        state_nxt = (right_r < eff_m) ? ST_S_ICMP : ST_S_KRD;
      end
      ST_S_ICMP: begin
        if (pa_rdata == t_rdata) begin
          right_nxt = right_r + PW'(1);
          state_nxt = ST_S_IRD;
        end else begin
          state_nxt = ST_S_NX;
        end
      end
      ST_S_KRD: begin
        pa_idx = left_r;
        t_idx  = TW'(ws_r) + TW'(left_r);
        if (left_r < ell_r) begin
          state_nxt = ST_S_KCMP;
        end else begin
          hit_nxt   = 1'b1;
          state_nxt = ST_S_NX;
        end
      end
      ST_S_KCMP: begin
        if (pa_rdata == t_rdata) begin
          left_nxt  = left_r + PW'(1);
          state_nxt = ST_S_KRD;
        end else begin
          state_nxt = ST_S_NX;
        end
      end
      ST_S_NX: begin
        nt_ridx   = right_r;
        state_nxt = ST_S_UPD;
      end
      ST_S_UPD: begin
        ws_nxt = ws_r + (TW+1)'(shift);
        priority if (right_r == ell_r) begin
          left_nxt = (left_r != '0) ? left_r - PW'(1) : '0;
        end else if (nx <= $signed({1'b0, ell_r})) begin
          left_nxt  = (nx > 0) ? PW'(nx) : '0;
          right_nxt = ell_r;
        end else begin
          left_nxt  = ell_r;
          right_nxt = PW'(nx);
        end
        if (hit_r) begin
          res_pos_nxt   = 12'(ws_r);
          res_found_nxt = 1'b1;
          res_fin_nxt   = 1'b0;
          state_nxt     = ST_OUT;
        end else begin
          state_nxt = ST_S_TOP;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg_valid && cfg_ready) begin
      prepared_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pl_r        <= 9'd1;
      tl_r        <= '0;
      prepared_r  <= 1'b0;
      ell_r       <= '0;
      right_r     <= '0;
      left_r      <= '0;
      ws_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      prepared_r <= prepared_nxt;
      ell_r      <= ell_nxt;
      right_r    <= right_nxt;
      left_r     <= left_nxt;
      ws_r       <= ws_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_PATTERN_LENGTH: pl_r <= cfg_data[8:0];
          REG_TEXT_LENGTH:    tl_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pi_r        <= pi_nxt;
    pj_r        <= pj_nxt;
    rl_r        <= rl_nxt;
    hit_r       <= hit_nxt;
    oob_r       <= oob_nxt;
    res_pos_r   <= res_pos_nxt;
    res_found_r <= res_found_nxt;
    res_fin_r   <= res_fin_nxt;
    if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
      out_pos_r   <= res_pos_r;
      out_found_r <= res_found_r;
      out_fin_r   <= res_fin_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_match_position = out_pos_r;
  assign out_found          = out_found_r;
  assign out_finished       = out_fin_r;

endmodule

// File: tb/tb_apostolico_crochemore_matcher.sv
// ----------------------------------------------------------------------------
// tb_apostolico_crochemore_matcher
// self-checking bench for the resumable exact string matcher
// ----------------------------------------------------------------------------
// the pattern store and the front of the text store are filled once after
// reset, and no text length reaches past that front, so every later scan
// reads defined symbols. a bench-side copy of the matcher state predicts each
// find result. directed cases cover the pattern length extremes, a pattern
// made of one repeated symbol, an empty text, ignored items and repeated
// finds after the end. random rounds use small alphabets, so matches are
// frequent. both sides idle at random, and the receiver holds off for one
// long stretch.
// ----------------------------------------------------------------------------
module tb_apostolico_crochemore_matcher;
  import acm_pkg::*;

  typedef struct packed {
    logic [11:0] pos;
    logic        found;
    logic        finished;
  } match_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  cmd_t        in_command = CMD_UNUSED;
  logic [11:0] in_address = '0;
  logic [7:0]  in_symbol = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] out_match_position;
  logic        out_found;
  logic        out_finished;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  reg_idx_t    cfg_index = REG_PATTERN_LENGTH;
  logic [12:0] cfg_data = '0;

  apostolico_crochemore_matcher dut (.*);

  always #5 clk = ~clk;

  // bench copy of the matcher state
  logic [7:0] pat_mem [256];
  logic [7:0] txt_mem [4096];
  int         next_tab [257];
  int         win_start, right_idx, left_idx, run_len, eff_m, eff_n;
  int         plen_reg = 1, tlen_reg = 0;
  bit         tables_ready = 0;

  match_t     match_q [$];
  int         errors = 0;
  int         finds_sent = 0, loads_sent = 0, hits_seen = 0, results_seen = 0;
  int         hold_cycles = 0;
  bit         no_idle = 0;

  function automatic int pat_at(int idx);
    return (idx < eff_m) ? int'(pat_mem[idx]) : 256;
  endfunction

  function automatic void build_tables();
    int m, pi, pj, r;
    m = plen_reg;
    if (m == 0) m = 1;
    if (m > 256) m = 256;
    eff_m = m;
    eff_n = (tlen_reg > 4096) ? 4096 : tlen_reg;
    next_tab[0] = -1;
    pi = 0;
    pj = -1;
    while (pi < m) begin
      while (pj > -1 && pat_at(pi) != pat_at(pj)) pj = next_tab[pj];
      pi++;
      pj++;
      if (pat_at(pi) == pat_at(pj)) next_tab[pi] = next_tab[pj];
      else next_tab[pi] = pj;
    end
    r = 1;
    while (r < m && pat_at(r - 1) == pat_at(r)) r++;
    if (r == m) r = 0;
    run_len = r;
    right_idx = r;
    left_idx = 0;
    win_start = 0;
    tables_ready = 1;
  endfunction

  function automatic match_t next_match();
    match_t res;
    int j, i, k, nx;
    bit hit;
    if (!tables_ready) build_tables();
    while (win_start <= eff_n - eff_m) begin
      j = win_start;
      i = right_idx;
      k = left_idx;
      hit = 0;
      while (i < eff_m && pat_at(i) == int'(txt_mem[(i + j) % 4096])) i++;
      if (i >= eff_m) begin
        while (k < run_len && pat_at(k) == int'(txt_mem[(j + k) % 4096])) k++;
        if (k >= run_len) hit = 1;
      end
      nx = next_tab[i];
      win_start += i - nx;
      if (i == run_len) begin
        k = (k > 0) ? k - 1 : 0;
      end else if (nx <= run_len) begin
        k = (nx > 0) ? nx : 0;
        i = run_len;
      end else begin
        k = run_len;
        i = nx;
      end
      right_idx = i;
      left_idx = k;
      if (hit) begin
        res.pos = j[11:0];
        res.found = 1'b1;
        res.finished = 1'b0;
        return res;
      end
    end
    res = '0;
    res.finished = 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result receiver with random stalls and requested hold-offs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else begin
      if ($urandom_range(0, 199) == 0) hold_cycles = $urandom_range(15, 60);
      out_ready <= ($urandom_range(0, 99) < 70);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (match_q.size() == 0) begin
        report_mismatch("unexpected item, position", out_match_position, -1);
      end else begin
        match_t want;
        want = match_q.pop_front();
        if (out_match_position !== want.pos)
          report_mismatch("match_position", out_match_position, want.pos);
        if (out_found !== want.found) report_mismatch("found", out_found, want.found);
        if (out_finished !== want.finished)
          report_mismatch("finished", out_finished, want.finished);
        if (want.found) hits_seen++;
      end
    end
  end

  task automatic send_item(cmd_t cmd, int addr, int sym);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_address <= addr[11:0];
    in_symbol <= sym[7:0];
    do @(posedge clk); while (!in_ready);
    case (cmd)
      CMD_LOAD_PATTERN: begin
        if (addr < 256) pat_mem[addr] = sym[7:0];
        tables_ready = 0;
        loads_sent++;
      end
      CMD_LOAD_TEXT: begin
        txt_mem[addr] = sym[7:0];
        tables_ready = 0;
        loads_sent++;
      end
      CMD_FIND_NEXT: begin
        match_q.push_back(next_match());
        finds_sent++;
      end
      default: ;
    endcase
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (match_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int value);
    wait_drain();
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[12:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_PATTERN_LENGTH) plen_reg = value & 'h1FF;
    else tlen_reg = value & 'h1FFF;
    tables_ready = 0;
    @(posedge clk);
  endtask

  task automatic test_fill_stores();
    no_idle = 1;
    for (int a = 0; a < 256; a++) send_item(CMD_LOAD_PATTERN, a, $urandom_range(0, 255));
    for (int a = 0; a < 256; a++) send_item(CMD_LOAD_TEXT, a, $urandom_range(0, 255));
    no_idle = 0;
  endtask

  task automatic test_directed();
    // empty text, then repeated finds past the end
    write_reg(REG_PATTERN_LENGTH, 1);
    write_reg(REG_TEXT_LENGTH, 0);
    send_item(CMD_FIND_NEXT, 0, 0);
    send_item(CMD_FIND_NEXT, 0, 0);
    // zero pattern length over the filled text
    write_reg(REG_PATTERN_LENGTH, 0);
    write_reg(REG_TEXT_LENGTH, 256);
    send_item(CMD_FIND_NEXT, 0, 0);
    send_item(CMD_FIND_NEXT, 0, 0);
    // oversized pattern length over the filled text
    write_reg(REG_PATTERN_LENGTH, 8191);
    write_reg(REG_TEXT_LENGTH, 256);
    send_item(CMD_FIND_NEXT, 0, 0);
    // pattern of one repeated symbol
    for (int a = 0; a < 4; a++) send_item(CMD_LOAD_PATTERN, a, 255);
    for (int a = 0; a < 10; a++) send_item(CMD_LOAD_TEXT, a, 255);
    write_reg(REG_PATTERN_LENGTH, 4);
    write_reg(REG_TEXT_LENGTH, 10);
    for (int f = 0; f < 9; f++) send_item(CMD_FIND_NEXT, 0, 0);
    // ignored items, zero symbols, text shorter than pattern
    send_item(CMD_UNUSED, 4095, 255);
    send_item(CMD_LOAD_PATTERN, 300, 0);
    send_item(CMD_LOAD_TEXT, 0, 0);
    send_item(CMD_FIND_NEXT, 0, 0);
    write_reg(REG_TEXT_LENGTH, 3);
    send_item(CMD_FIND_NEXT, 0, 0);
  endtask

  task automatic test_random_rounds();
    int sent, m, n, sym_a, sym_b, finds, r;
    sent = 0;
    while (sent < 270) begin
      m = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 256) : $urandom_range(0, 48);
      sym_a = $urandom_range(0, 255);
      sym_b = $urandom_range(0, 255);
      write_reg(REG_PATTERN_LENGTH, m);
      write_reg(REG_TEXT_LENGTH, n);
      for (int a = 0; a < m; a++) begin
        send_item(CMD_LOAD_PATTERN, a, $urandom_range(0, 1) ? sym_a : sym_b);
        sent++;
      end
      for (int a = 0; a < n && a < 48; a++) begin
        send_item(CMD_LOAD_TEXT, a, $urandom_range(0, 1) ? sym_a : sym_b);
        sent++;
      end
      finds = $urandom_range(2, 10);
      for (int f = 0; f < finds; f++) begin
        r = $urandom_range(0, 19);
        if (r == 0) send_item(CMD_UNUSED, $urandom_range(0, 4095), $urandom_range(0, 255));
        else if (r == 1) send_item(CMD_LOAD_PATTERN, $urandom_range(256, 4095), 0);
        else if (r == 2) send_item(CMD_LOAD_TEXT, $urandom_range(0, 47), sym_a);
        send_item(CMD_FIND_NEXT, 0, 0);
        sent++;
      end
    end
  endtask

  task automatic test_output_hold();
    write_reg(REG_PATTERN_LENGTH, 1);
    write_reg(REG_TEXT_LENGTH, 40);
    hold_cycles = 400;
    for (int f = 0; f < 6; f++) begin
      send_item(CMD_FIND_NEXT, 0, 0);
      send_item(CMD_LOAD_TEXT, 100 + f, f);
    end
    wait_drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_stores();
    test_directed();
    test_random_rounds();
    test_output_hold();
    wait_drain();
    repeat (50) @(posedge clk);
    $display("covered %0d loads and %0d finds, %0d results with %0d matches",
             loads_sent, finds_sent, results_seen, hits_seen);
    $display("length extremes, repeated-symbol pattern, ignored items, long output hold");
    if (errors == 0) $display("apostolico_crochemore_matcher verification clean");
    else $display("apostolico_crochemore_matcher verification failed");
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout with %0d results outstanding", match_q.size());
    $display("apostolico_crochemore_matcher verification failed");
    $finish;
  end

endmodule
